### rtl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants for the response packet deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

   // Header length in bytes: two start bytes, code, two length/seq bytes
   localparam int unsigned HeaderBytes = 5;

   // Result item kinds
   localparam logic [1:0] KIND_DATA      = 2'd0;
   localparam logic [1:0] KIND_GOOD      = 2'd1;
   localparam logic [1:0] KIND_CSUM      = 2'd2;
   localparam logic [1:0] KIND_MALFORMED = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_START_ONE   = 2'd0;
   localparam logic [1:0] CSR_START_ACK   = 2'd1;
   localparam logic [1:0] CSR_START_ASYNC = 2'd2;

   typedef struct packed {
      logic [1:0]  item_kind;
      logic        frame_async;
      logic [7:0]  response_code;
      logic [7:0]  sequence_number;
      logic [7:0]  async_code;
      logic [7:0]  payload_byte;
      logic [15:0] payload_count;
   } rpd_result_type;

   // Builds one result item; header codes are routed by frame type
   function automatic rpd_result_type rpd_make_result(
      input logic [1:0]  kind,
      input logic        is_async,
      input logic [7:0]  code,
      input logic [7:0]  seq,
      input logic [7:0]  data,
      input logic [15:0] count
   );
      rpd_result_type r;
      r.item_kind       = kind;
      r.frame_async     = is_async;
      r.response_code   = is_async ? 8'd0 : code;
      r.sequence_number = is_async ? 8'd0 : seq;
      r.async_code      = is_async ? code : 8'd0;
      r.payload_byte    = data;
      r.payload_count   = count;
      return r;
   endfunction

endpackage

### rtl/response_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// response_packet_deframer_unit
// Splits a received link byte stream into acknowledge and async frames.
// ----------------------------------------------------------------------------
// Takes one link byte per req transaction and returns at most one rsp
// transaction per byte. The block hunts for start_byte_one; the next byte
// picks an acknowledge frame (code, sequence id, 8-bit length) or an async
// frame (id code, 16-bit big-endian length). Length counts payload plus the
// checksum byte. Every payload byte comes out as a data item; the checksum
// byte produces a good or checksum-error status item. A bad second start
// byte or a zero length produces a malformed item and the parser resyncs.
// Throughput is one byte per clock unless stalled: the parser state and
// the result register are loaded as the byte is accepted, so rsp_valid
// rises in the cycle after. A byte is taken while a finished result waits,
// as long as that result is being taken in the same cycle; req_stall rises
// only when the result register is full and rsp_stall is high.
// Configuration writes are always ready and should be issued idle.
// ----------------------------------------------------------------------------
module response_packet_deframer_unit
   import rpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,

   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_item_kind,
   output logic        rsp_frame_async,
   output logic [7:0]  rsp_response_code,
   output logic [7:0]  rsp_sequence_number,
   output logic [7:0]  rsp_async_code,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_payload_count,

   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // Parser phases, one per header byte then payload and checksum
   localparam logic [2:0] PH_HUNT     = 3'd0;
   localparam logic [2:0] PH_SOP2     = 3'd1;
   localparam logic [2:0] PH_CODE     = 3'd2;
   localparam logic [2:0] PH_HDR3     = 3'd3;
   localparam logic [2:0] PH_LAST_HDR = 3'(HeaderBytes - 1);
   localparam logic [2:0] PH_PAYLOAD  = 3'(HeaderBytes);
   localparam logic [2:0] PH_CHECK    = 3'(HeaderBytes + 1);

   // Configuration
   logic [7:0]  start_one_ff;
   logic [7:0]  start_ack_ff;
   logic [7:0]  start_async_ff;

   // Parser state
   logic [2:0]  phase_ff,   phase_in;
   logic        async_ff,   async_in;
   logic [7:0]  code_ff,    code_in;
   logic [7:0]  seq_ff,     seq_in;
   logic [15:0] length_ff,  length_in;
   logic [15:0] left_ff,    left_in;
   logic [7:0]  sum_ff,     sum_in;

   // Result register
   logic           rsp_valid_ff, rsp_valid_in;
   rpd_result_type result_ff,    result_in;

   logic        accept;
   logic        take;
   logic        emit;
   logic [7:0]  b;
   logic [15:0] hdr_length;
   logic [15:0] count;

   assign csr_ready = 1'b1;

   // Output register frees up when its transaction completes
   assign take      = rsp_valid_ff & ~rsp_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign b         = req_rx_byte;

   // Length as completed by the last header byte
   assign hdr_length = async_ff ? {length_ff[15:8], b} : {8'd0, b};
   assign count      = length_ff - 16'd1;

   always_comb begin
      phase_in  = phase_ff;
      async_in  = async_ff;
      code_in   = code_ff;
      seq_in    = seq_ff;
      length_in = length_ff;
      left_in   = left_ff;
      sum_in    = sum_ff;
      emit      = 1'b0;
      result_in = rpd_make_result(KIND_DATA, async_ff, code_ff, seq_ff, 8'd0, 16'd0);

      case (phase_ff)
         PH_HUNT: begin
            if (b == start_one_ff) phase_in = PH_SOP2;
         end
         PH_SOP2: begin
            if (b == start_ack_ff) begin
               async_in = 1'b0;
               phase_in = PH_CODE;
            end else if (b == start_async_ff) begin
               async_in = 1'b1;
               phase_in = PH_CODE;
            end else begin
               // bad second start byte: report and resync
               async_in  = 1'b0;
               code_in   = 8'd0;
               seq_in    = 8'd0;
               length_in = 16'd0;
               emit      = 1'b1;
               result_in = rpd_make_result(KIND_MALFORMED, 1'b0, 8'd0, 8'd0, 8'd0, 16'd0);
               phase_in  = (b == start_one_ff) ? PH_SOP2 : PH_HUNT;
            end
         end
         PH_CODE: begin
            code_in   = b;
            seq_in    = 8'd0;
            length_in = 16'd0;
            sum_in    = b;
            phase_in  = PH_HDR3;
         end
         PH_HDR3: begin
            if (async_ff) length_in = {b, 8'd0};
            else          seq_in    = b;
            sum_in   = sum_ff + b;
            phase_in = PH_LAST_HDR;
         end
         PH_LAST_HDR: begin
            length_in = hdr_length;
            sum_in    = sum_ff + b;
            if (hdr_length == 16'd0) begin
               emit      = 1'b1;
               result_in = rpd_make_result(KIND_MALFORMED, async_ff, code_ff, seq_ff,
                                           8'd0, 16'd0);
               phase_in  = PH_HUNT;
            end else begin
               left_in  = hdr_length - 16'd1;
               phase_in = (hdr_length == 16'd1) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            emit      = 1'b1;
            result_in = rpd_make_result(KIND_DATA, async_ff, code_ff, seq_ff, b, count);
            sum_in    = sum_ff + b;
            left_in   = left_ff - 16'd1;
            if (left_ff == 16'd1) phase_in = PH_CHECK;
         end
         PH_CHECK: begin
            emit      = 1'b1;
            result_in = rpd_make_result((b == ~sum_ff) ? KIND_GOOD : KIND_CSUM,
                                        async_ff, code_ff, seq_ff, 8'd0, count);
            phase_in  = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_comb begin
      if (accept)    rsp_valid_in = emit;
      else if (take) rsp_valid_in = 1'b0;
      else           rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_one_ff   <= 8'd255;
         start_ack_ff   <= 8'd255;
         start_async_ff <= 8'd254;
         phase_ff       <= PH_HUNT;
         async_ff       <= 1'b0;
         code_ff        <= 8'd0;
         seq_ff         <= 8'd0;
         length_ff      <= 16'd0;
         left_ff        <= 16'd0;
         sum_ff         <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_ONE:   start_one_ff   <= csr_data;
               CSR_START_ACK:   start_ack_ff   <= csr_data;
               CSR_START_ASYNC: start_async_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff  <= phase_in;
            async_ff  <= async_in;
            code_ff   <= code_in;
            seq_ff    <= seq_in;
            length_ff <= length_in;
            left_ff   <= left_in;
            sum_ff    <= sum_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded only when a byte produces an item
   always_ff @(posedge clock) begin
      if (accept && emit) result_ff <= result_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_item_kind       = result_ff.item_kind;
   assign rsp_frame_async     = result_ff.frame_async;
   assign rsp_response_code   = result_ff.response_code;
   assign rsp_sequence_number = result_ff.sequence_number;
   assign rsp_async_code      = result_ff.async_code;
   assign rsp_payload_byte    = result_ff.payload_byte;
   assign rsp_payload_count   = result_ff.payload_count;

endmodule
